// File: rtl/ppq_pkg.sv
// Shared types and codes for the preemptive priority ready queue.
// No dependencies.
`default_nettype none

package ppq_pkg;

  localparam logic OP_INSERT   = 1'b0;
  localparam logic OP_SCHEDULE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } ppq_state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } ppq_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } ppq_sts_t;

endpackage

`default_nettype wire

// File: rtl/ppq_ctrl.sv
// Sequencer for the ready queue: load, table scan, drain, commit.
// Depends on ppq_pkg.
`default_nettype none

module ppq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire ppq_pkg::ppq_sts_t sts,
  output ppq_pkg::ppq_cmd_t    cmd
);

  ppq_pkg::ppq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ppq_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ppq_pkg::ST_SCAN;
        end
      end
      ppq_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ppq_pkg::ST_DRAIN;
        end
      end
      ppq_pkg::ST_DRAIN: begin
        state_nxt = ppq_pkg::ST_DONE;
      end
      ppq_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ppq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ppq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/ppq_dp.sv
// Datapath: slot table memory, valid bits, scan pipeline, running task and result word.
// Depends on ppq_pkg.
`default_nettype none

module ppq_dp #(
  parameter int TABLE_DEPTH   = 16,
  parameter int ID_BITS       = 8,
  parameter int PRIORITY_BITS = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_op,
  input  wire logic [ID_BITS-1:0]       in_task_id,
  input  wire logic [PRIORITY_BITS-1:0] in_task_priority,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_preempted,
  output logic [ID_BITS-1:0]            out_running_id,
  output logic [PRIORITY_BITS-1:0]      out_running_priority,
  output logic [ID_BITS-1:0]            out_displaced_id,
  output logic                          out_table_full,
  input  wire ppq_pkg::ppq_cmd_t        cmd,
  output ppq_pkg::ppq_sts_t             sts
);

  localparam int IDXW = $clog2(TABLE_DEPTH);

  logic [ID_BITS-1:0]       mem_id  [TABLE_DEPTH];
  logic [PRIORITY_BITS-1:0] mem_pr  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   valid_r;

  logic                     op_r;
  logic [ID_BITS-1:0]       tid_r;
  logic [PRIORITY_BITS-1:0] tpr_r;
  logic [IDXW-1:0]          idx_r;

  logic                     rd_live_r;
  logic                     rd_vld_r;
  logic [IDXW-1:0]          rd_idx_r;
  logic [ID_BITS-1:0]       rd_id_r;
  logic [PRIORITY_BITS-1:0] rd_pr_r;

  logic                     free_found_r;
  logic [IDXW-1:0]          free_idx_r;
  logic                     best_found_r;
  logic [IDXW-1:0]          best_idx_r;
  logic [ID_BITS-1:0]       best_id_r;
  logic [PRIORITY_BITS-1:0] best_pr_r;

  logic [ID_BITS-1:0]       cur_id_r;
  logic [PRIORITY_BITS-1:0] cur_pr_r;

  logic                     out_valid_r;
  logic                     out_preempted_r;
  logic [ID_BITS-1:0]       out_running_id_r;
  logic [PRIORITY_BITS-1:0] out_running_priority_r;
  logic [ID_BITS-1:0]       out_displaced_id_r;
  logic                     out_table_full_r;

  logic                     take_best;
  logic                     do_insert;
  logic                     do_preempt;

  assign sts.scan_last = (idx_r == IDXW'(TABLE_DEPTH - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign take_best = rd_vld_r &&
                     (!best_found_r || (rd_pr_r > best_pr_r) ||
                      ((rd_pr_r == best_pr_r) && (rd_id_r < best_id_r)));

  assign do_insert  = (op_r == ppq_pkg::OP_INSERT) && free_found_r;
  assign do_preempt = (op_r == ppq_pkg::OP_SCHEDULE) && best_found_r &&
                      (best_pr_r > cur_pr_r);

  // slot table
  always_ff @(posedge clk) begin
    if (cmd.commit && do_insert) begin
      mem_id[free_idx_r] <= tid_r;
      mem_pr[free_idx_r] <= tpr_r;
    end
    rd_id_r  <= mem_id[idx_r];
    rd_pr_r  <= mem_pr[idx_r];
    rd_vld_r <= valid_r[idx_r];
    rd_idx_r <= idx_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      tid_r <= in_task_id;
      tpr_r <= in_task_priority;
    end
    if (rd_live_r && take_best) begin
      best_idx_r <= rd_idx_r;
      best_id_r  <= rd_id_r;
      best_pr_r  <= rd_pr_r;
    end
    if (rd_live_r && !rd_vld_r && !free_found_r) begin
      free_idx_r <= rd_idx_r;
    end
    if (cmd.commit) begin
      out_preempted_r        <= do_preempt;
      out_running_id_r       <= do_preempt ? best_id_r : cur_id_r;
      out_running_priority_r <= do_preempt ? best_pr_r : cur_pr_r;
      out_displaced_id_r     <= do_preempt ? cur_id_r : '0;
      out_table_full_r       <= (op_r == ppq_pkg::OP_INSERT) && !free_found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      idx_r        <= '0;
      rd_live_r    <= 1'b0;
      free_found_r <= 1'b0;
      best_found_r <= 1'b0;
      cur_id_r     <= '0;
      cur_pr_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_live_r <= cmd.issue;
      if (cmd.load) begin
        idx_r        <= '0;
        free_found_r <= 1'b0;
        best_found_r <= 1'b0;
      end else if (cmd.issue) begin
        idx_r <= idx_r + 1'b1;
      end
      if (rd_live_r && take_best) begin
        best_found_r <= 1'b1;
      end
      if (rd_live_r && !rd_vld_r) begin
        free_found_r <= 1'b1;
      end
      if (cmd.commit && do_insert) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (cmd.commit && do_preempt) begin
        valid_r[best_idx_r] <= 1'b0;
        cur_id_r            <= best_id_r;
        cur_pr_r            <= best_pr_r;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_preempted        = out_preempted_r;
  assign out_running_id       = out_running_id_r;
  assign out_running_priority = out_running_priority_r;
  assign out_displaced_id     = out_displaced_id_r;
  assign out_table_full       = out_table_full_r;

endmodule

`default_nettype wire

// File: rtl/preemptive_priority_ready_queue.sv
// Preemptive priority ready queue top level: sequencer plus datapath.
// Result word registered at commit, after the table scan, drain and done states; commit waits while the output stalls.
// A new input word is taken only after the previous one is committed; the table scan reads one slot per cycle.
// Reset (rst_n low, synchronous): table empty, running task id 0 priority 0, no result pending.
// Depends on ppq_pkg, ppq_ctrl, ppq_dp.
`default_nettype none

module preemptive_priority_ready_queue #(
  parameter int TABLE_DEPTH   = 16,
  parameter int ID_BITS       = 8,
  parameter int PRIORITY_BITS = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_op,
  input  wire logic [ID_BITS-1:0]       in_task_id,
  input  wire logic [PRIORITY_BITS-1:0] in_task_priority,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_preempted,
  output logic [ID_BITS-1:0]            out_running_id,
  output logic [PRIORITY_BITS-1:0]      out_running_priority,
  output logic [ID_BITS-1:0]            out_displaced_id,
  output logic                          out_table_full
);

  ppq_pkg::ppq_cmd_t cmd;
  ppq_pkg::ppq_sts_t sts;

  ppq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ppq_dp #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .ID_BITS       (ID_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_op                (in_op),
    .in_task_id           (in_task_id),
    .in_task_priority     (in_task_priority),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_preempted        (out_preempted),
    .out_running_id       (out_running_id),
    .out_running_priority (out_running_priority),
    .out_displaced_id     (out_displaced_id),
    .out_table_full       (out_table_full),
    .cmd                  (cmd),
    .sts                  (sts)
  );

endmodule

`default_nettype wire

// File: rtl/ppq_checker.sv
// Port-level checks for the ready queue, bound to the top level.
// Depends on preemptive_priority_ready_queue.
`default_nettype none

module ppq_checker #(
  parameter int ID_BITS       = 8,
  parameter int PRIORITY_BITS = 4
) (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic                     out_preempted,
  input wire logic [ID_BITS-1:0]       out_running_id,
  input wire logic [PRIORITY_BITS-1:0] out_running_priority,
  input wire logic [ID_BITS-1:0]       out_displaced_id,
  input wire logic                     out_table_full
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_preempted) &&
      $stable(out_running_id) && $stable(out_running_priority) &&
      $stable(out_displaced_id) && $stable(out_table_full))
    else $error("result word changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while a word is in progress");

  a_preempt_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_preempted |-> !out_table_full && (out_running_priority != '0))
    else $error("preemption with full flag or zero priority");

  a_displaced_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_preempted |-> (out_displaced_id == '0))
    else $error("displaced id set without preemption");

endmodule

bind preemptive_priority_ready_queue ppq_checker #(
  .ID_BITS       (ID_BITS),
  .PRIORITY_BITS (PRIORITY_BITS)
) u_ppq_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_preempted        (out_preempted),
  .out_running_id       (out_running_id),
  .out_running_priority (out_running_priority),
  .out_displaced_id     (out_displaced_id),
  .out_table_full       (out_table_full)
);

`default_nettype wire
